>>> rtl/dewp_pkg.sv
// shared types and constants for the digitizer event word parser
package dewp_pkg;

    // number of digitizer channels, two per channel pair
    localparam int NUM_CHANNELS = 8;

    // pairs covered by the 4-bit pair mask in the board header
    localparam int PAIR_LIMIT = ((NUM_CHANNELS / 2) < 4) ? (NUM_CHANNELS / 2) : 4;

    // depth of the queue between parser and output stage
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    // packed result payload width: 3 + 31 + 14 + 14 + 8 + 2
    localparam int OUT_TDATA_W = 72;

    // error codes carried with an error result
    localparam logic [1:0] ERR_FORMAT   = 2'd1;
    localparam logic [1:0] ERR_DISABLED = 2'd2;

    // result kinds
    typedef enum logic [1:0] {
        KIND_TIME_TAG    = 2'd0,
        KIND_SAMPLE_PAIR = 2'd1,
        KIND_BOARD_DONE  = 2'd2,
        KIND_ERROR       = 2'd3
    } kind_t;

    // one parsed result as it travels through the queue
    typedef struct packed {
        kind_t       kind;
        logic [2:0]  channel;
        logic [30:0] data;          // low 31 bits of the source word
        logic        last_pair;
        logic [7:0]  present_mask;
        logic [1:0]  error_code;
    } result_t;

endpackage

>>> rtl/digitizer_event_word_parser_unit.sv
// top level of the digitizer event word parser
//
//  channel  dir  ports             contents
//  s_       in   tdata[31:0]       readout word
//                tuser[0]          start of board event
//  m_       out  tdata[71:0]       channel, time tag, samples, present mask, error code
//                tuser[1:0]        result kind
//                tlast             last sample pair of an event
//
// one request per cycle in steady state; a word's result is queued at the edge that takes
// it and reaches m_ through the output register once that register is free.
// a four-entry queue sits between parser and output register, so s_tready only
// drops when the queue is full under a stalled m_tready.
// reset (aresetn low, synchronous) returns the parser to waiting for a start word
// and empties queue and output register.
module digitizer_event_word_parser_unit import dewp_pkg::*; (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [31:0]            s_tdata,   // word
    input  logic [0:0]             s_tuser,   // start_of_event
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // channel[2:0], time_tag[33:3], sample_low[47:34], sample_high[61:48],
    // present_mask[69:62], error_code[71:70]
    output logic [OUT_TDATA_W-1:0] m_tdata,
    output logic [1:0]             m_tuser,   // kind
    output logic                   m_tlast    // last_pair
);

    logic    q_full;
    logic    q_empty;
    logic    q_push;
    logic    q_pop;
    result_t q_in;
    result_t q_out;

    // parser
    dewp_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_word    (s_tdata),
        .in_start   (s_tuser[0]),
        .queue_full (q_full),
        .res_push   (q_push),
        .res_data   (q_in)
    );

    // result queue
    dewp_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_out),
        .empty     (q_empty)
    );

    // output stage
    dewp_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .queue_empty (q_empty),
        .queue_data  (q_out),
        .queue_pop   (q_pop),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast)
    );

endmodule

>>> rtl/dewp_front.sv
// parser front end: walks board, channel and event headers, one word per cycle while the queue has room
module dewp_front import dewp_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [31:0] in_word,
    input  logic        in_start,
    input  logic        queue_full,
    output logic        res_push,
    output result_t     res_data
);

    localparam logic [3:0] PAIR_VALID = 4'((1 << PAIR_LIMIT) - 1);

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_BOARD,
        PH_CHAN,
        PH_EVENT,
        PH_DONE_PENDING
    } phase_t;

    typedef struct packed {
        logic       found;
        logic [1:0] idx;
    } pair_sel_t;

    // lowest enabled pair at or above from
    function automatic pair_sel_t next_pair(input logic [3:0] mask, input logic [2:0] from);
        pair_sel_t s;
        s.found = 1'b0;
        s.idx   = 2'd0;
        for (int p = PAIR_LIMIT - 1; p >= 0; p--) begin
            if (mask[p] && (3'(p) >= from)) begin
                s.found = 1'b1;
                s.idx   = 2'(p);
            end
        end
        return s;
    endfunction

    phase_t      phase_reg, phase_next;
    logic [1:0]  hdr_reg, hdr_next;
    logic [3:0]  mask_reg, mask_next;
    logic [1:0]  pair_reg, pair_next;
    logic [14:0] left_reg, left_next;
    logic [13:0] ev_idx_reg, ev_idx_next;
    logic [13:0] wave_reg, wave_next;
    logic        charge_reg, charge_next;
    logic        extras_reg, extras_next;
    logic        odd_reg, odd_next;
    logic [7:0]  seen_reg, seen_next;

    logic        accept;
    logic        complete;
    logic [14:0] size_cur;
    logic [14:0] size_hdr;
    logic [14:0] blk_size;
    logic [14:0] left_evt;
    logic [2:0]  tag_ch;
    pair_sel_t   np_first;
    pair_sel_t   np_after;

    assign in_ready = !queue_full;
    assign accept   = in_valid && in_ready;

    // event sizes for the current and the incoming channel header
    assign size_cur = 15'd1 + {1'b0, wave_reg} + {14'd0, charge_reg} + {14'd0, extras_reg};
    assign size_hdr = 15'd1 + {1'b0, in_word[11:0], 2'b00}
                    + {14'd0, in_word[30]} + {14'd0, in_word[28]};
    assign blk_size = in_word[14:0];
    assign left_evt = (ev_idx_reg == 14'd0) ? (left_reg - size_cur) : left_reg;
    assign tag_ch   = {pair_reg, in_word[31]};

    // pair search from the bottom and from the one after the current pair
    assign np_first = next_pair(mask_reg, 3'd0);
    assign np_after = next_pair(mask_reg, {1'b0, pair_reg} + 3'd1);

    // next state and result
    always_comb begin
        phase_next  = phase_reg;
        hdr_next    = hdr_reg;
        mask_next   = mask_reg;
        pair_next   = pair_reg;
        left_next   = left_reg;
        ev_idx_next = ev_idx_reg;
        wave_next   = wave_reg;
        charge_next = charge_reg;
        extras_next = extras_reg;
        odd_next    = odd_reg;
        seen_next   = seen_reg;
        complete    = 1'b0;
        res_push    = 1'b0;
        res_data    = '0;

        if (accept) begin
            // board done held over from the previous word
            if (phase_reg == PH_DONE_PENDING) begin
                res_push              = 1'b1;
                res_data.kind         = KIND_BOARD_DONE;
                res_data.present_mask = seen_reg;
                phase_next            = PH_IDLE;
            end

            if (in_start) begin
                seen_next  = 8'd0;
                mask_next  = 4'd0;
                pair_next  = 2'd0;
                hdr_next   = 2'd1;
                phase_next = PH_BOARD;
            end else begin
                unique case (phase_reg)
                    PH_BOARD: begin
                        if (hdr_reg == 2'd1) begin
                            mask_next = in_word[3:0] & PAIR_VALID;
                        end
                        if (hdr_reg == 2'd3) begin
                            if (np_first.found) begin
                                pair_next  = np_first.idx;
                                phase_next = PH_CHAN;
                                hdr_next   = 2'd0;
                            end else begin
                                complete = 1'b1;
                            end
                        end else begin
                            hdr_next = hdr_reg + 2'd1;
                        end
                    end
                    PH_CHAN: begin
                        if (hdr_reg == 2'd0) begin
                            if (!in_word[31]) begin
                                res_push            = 1'b1;
                                res_data.kind       = KIND_ERROR;
                                res_data.channel    = {pair_reg, 1'b0};
                                res_data.error_code = ERR_FORMAT;
                                phase_next          = PH_IDLE;
                            end else begin
                                left_next = (blk_size >= 15'd2) ? (blk_size - 15'd2) : 15'd0;
                                hdr_next  = 2'd1;
                            end
                        end else if (!in_word[27] || !in_word[29]) begin
                            res_push            = 1'b1;
                            res_data.kind       = KIND_ERROR;
                            res_data.channel    = {pair_reg, 1'b0};
                            res_data.error_code = ERR_DISABLED;
                            phase_next          = PH_IDLE;
                        end else begin
                            wave_next   = {in_word[11:0], 2'b00};
                            charge_next = in_word[30];
                            extras_next = in_word[28];
                            if (left_reg >= size_hdr) begin
                                phase_next  = PH_EVENT;
                                ev_idx_next = 14'd0;
                            end else if (np_after.found) begin
                                pair_next  = np_after.idx;
                                phase_next = PH_CHAN;
                                hdr_next   = 2'd0;
                            end else begin
                                complete = 1'b1;
                            end
                        end
                    end
                    PH_EVENT: begin
                        if (ev_idx_reg == 14'd0) begin
                            odd_next         = in_word[31];
                            seen_next        = seen_reg | (8'd1 << tag_ch);
                            res_push         = 1'b1;
                            res_data.kind    = KIND_TIME_TAG;
                            res_data.channel = tag_ch;
                            res_data.data    = in_word[30:0];
                        end else if (ev_idx_reg <= wave_reg) begin
                            res_push           = 1'b1;
                            res_data.kind      = KIND_SAMPLE_PAIR;
                            res_data.channel   = {pair_reg, odd_reg};
                            res_data.data      = in_word[30:0];
                            res_data.last_pair = (ev_idx_reg == wave_reg);
                        end
                        left_next   = left_evt;
                        ev_idx_next = ev_idx_reg + 14'd1;
                        // end of event: another one, the next pair, or board end
                        if (({1'b0, ev_idx_reg} + 15'd1) >= size_cur) begin
                            if (left_evt >= size_cur) begin
                                ev_idx_next = 14'd0;
                            end else if (np_after.found) begin
                                pair_next  = np_after.idx;
                                phase_next = PH_CHAN;
                                hdr_next   = 2'd0;
                            end else begin
                                complete = 1'b1;
                            end
                        end
                    end
                    default: begin
                    end
                endcase
            end

            // board done now, or on the next word if this one gave a result
            if (complete) begin
                if (!res_push) begin
                    res_push              = 1'b1;
                    res_data.kind         = KIND_BOARD_DONE;
                    res_data.present_mask = seen_next;
                    phase_next            = PH_IDLE;
                end else begin
                    phase_next = PH_DONE_PENDING;
                end
            end
        end
    end

    // parser state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_IDLE;
            hdr_reg    <= 2'd0;
            mask_reg   <= 4'd0;
            pair_reg   <= 2'd0;
            left_reg   <= 15'd0;
            ev_idx_reg <= 14'd0;
            wave_reg   <= 14'd0;
            charge_reg <= 1'b0;
            extras_reg <= 1'b0;
            odd_reg    <= 1'b0;
            seen_reg   <= 8'd0;
        end else begin
            phase_reg  <= phase_next;
            hdr_reg    <= hdr_next;
            mask_reg   <= mask_next;
            pair_reg   <= pair_next;
            left_reg   <= left_next;
            ev_idx_reg <= ev_idx_next;
            wave_reg   <= wave_next;
            charge_reg <= charge_next;
            extras_reg <= extras_next;
            odd_reg    <= odd_next;
            seen_reg   <= seen_next;
        end
    end

endmodule

>>> rtl/dewp_queue.sv
// short result queue between the parser and the output stage
module dewp_queue import dewp_pkg::*; (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    push,
    input  result_t push_data,
    output logic    full,
    input  logic    pop,
    output result_t pop_data,
    output logic    empty
);

    result_t             store [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_CW-1:0] count_reg, count_next;

    assign full     = (count_reg == QUEUE_CW'(QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = store[rd_ptr_reg];

    // pointer and count update
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge aclk) begin
        if (push) begin
            store[wr_ptr_reg] <= push_data;
        end
    end

endmodule

>>> rtl/dewp_back.sv
// output stage: formats queued results into the result channel register
module dewp_back import dewp_pkg::*; (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   queue_empty,
    input  result_t                queue_data,
    output logic                   queue_pop,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,
    output logic [1:0]             m_tuser,
    output logic                   m_tlast
);

    logic                   valid_reg, valid_next;
    logic [OUT_TDATA_W-1:0] data_reg, data_next;
    logic [1:0]             user_reg, user_next;
    logic                   last_reg, last_next;

    logic [30:0] time_tag;
    logic [13:0] sample_low;
    logic [13:0] sample_high;
    logic        is_tag;
    logic        is_sample;

    assign queue_pop = !queue_empty && (!valid_reg || m_tready);

    // field extraction by kind
    assign is_tag      = (queue_data.kind == KIND_TIME_TAG);
    assign is_sample   = (queue_data.kind == KIND_SAMPLE_PAIR);
    assign time_tag    = is_tag ? queue_data.data : 31'd0;
    assign sample_low  = is_sample ? queue_data.data[13:0] : 14'd0;
    assign sample_high = is_sample ? queue_data.data[29:16] : 14'd0;

    // output register load
    always_comb begin
        valid_next = valid_reg;
        data_next  = data_reg;
        user_next  = user_reg;
        last_next  = last_reg;
        if (queue_pop) begin
            valid_next = 1'b1;
            data_next  = {queue_data.error_code, queue_data.present_mask, sample_high,
                          sample_low, time_tag, queue_data.channel};
            user_next  = queue_data.kind;
            last_next  = queue_data.last_pair;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
        user_reg <= user_next;
        last_reg <= last_next;
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tuser  = user_reg;
    assign m_tlast  = last_reg;

endmodule

>>> sim/event_word_scoreboard_pkg.sv
// predictor and scoreboard for the digitizer event word parser testbench
package event_word_scoreboard_pkg;
    import dewp_pkg::*;

    // channel header flag bits
    localparam logic [31:0] FORMAT_FLAG   = 32'h8000_0000;
    localparam logic [31:0] CHARGE_FLAG   = 32'h4000_0000;
    localparam logic [31:0] TIME_TAG_FLAG = 32'h2000_0000;
    localparam logic [31:0] EXTRAS_FLAG   = 32'h1000_0000;
    localparam logic [31:0] WAVEFORM_FLAG = 32'h0800_0000;

    // where the parser is within a board
    typedef enum logic [2:0] {
        WAIT_START,
        BOARD_HEADER,
        CHANNEL_HEADER,
        EVENT_BODY,
        DONE_PENDING
    } parse_phase_t;

    // one parsed result, unpacked from the m_ channel
    typedef struct packed {
        kind_t       kind;
        logic [2:0]  channel;
        logic [30:0] time_tag;
        logic [13:0] sample_low;
        logic [13:0] sample_high;
        logic        last_pair;
        logic [7:0]  present_mask;
        logic [1:0]  error_code;
    } parsed_result_t;

    class event_word_scoreboard;
        parsed_result_t pending_results[$];
        int             mismatch_count;

        // parser state mirrored at the block's widths, but for a wider pair index
        parse_phase_t phase;
        logic [1:0]   header_idx;
        logic [3:0]   pair_mask;
        logic [2:0]   pair_idx;
        logic [14:0]  block_left;
        logic [13:0]  event_idx;
        logic [13:0]  wave_words;
        logic         has_charge;
        logic         has_extras;
        logic         event_odd;
        logic [7:0]   channels_seen;

        function new();
            phase          = WAIT_START;
            header_idx     = '0;
            pair_mask      = '0;
            pair_idx       = '0;
            block_left     = '0;
            event_idx      = '0;
            wave_words     = '0;
            has_charge     = 1'b0;
            has_extras     = 1'b0;
            event_odd      = 1'b0;
            channels_seen  = '0;
            mismatch_count = 0;
        endfunction

        // append one expected result at the tail
        function void queue_expected(parsed_result_t r);
            pending_results.insert(pending_results.size(), r);
        endfunction

        function int event_words();
            return 1 + int'(wave_words) + int'(has_charge) + int'(has_extras);
        endfunction

        // select the first enabled pair at or above from; 1 when none is left
        function bit seek_pair(int from);
            int p;
            for (p = from; p < PAIR_LIMIT; p++) begin
                if (pair_mask[p]) begin
                    pair_idx   = 3'(p);
                    phase      = CHANNEL_HEADER;
                    header_idx = '0;
                    return 1'b0;
                end
            end
            return 1'b1;
        endfunction

        // another event if one fits in the block, else the next pair
        function bit next_event_or_pair();
            if (int'(block_left) >= event_words()) begin
                phase     = EVENT_BODY;
                event_idx = '0;
                return 1'b0;
            end
            return seek_pair(int'(pair_idx) + 1);
        endfunction

        function void push_board_done();
            parsed_result_t r;
            r              = '0;
            r.kind         = KIND_BOARD_DONE;
            r.present_mask = channels_seen;
            queue_expected(r);
            phase = WAIT_START;
        endfunction

        // advance the predictor by one accepted request
        function void note_request(logic [31:0] w, logic sof);
            parsed_result_t r;
            bit             got;
            bit             complete;
            logic [2:0]     ch;
            r        = '0;
            got      = 1'b0;
            complete = 1'b0;

            // a done held back from the previous word leaves first
            if (phase == DONE_PENDING) begin
                push_board_done();
                if (!sof)
                    return;
            end

            if (sof) begin
                channels_seen = '0;
                pair_mask     = '0;
                pair_idx      = '0;
                header_idx    = 2'd1;
                phase         = BOARD_HEADER;
                return;
            end

            case (phase)
                BOARD_HEADER: begin
                    if (header_idx == 2'd1)
                        pair_mask = w[3:0] & 4'((1 << PAIR_LIMIT) - 1);
                    if (header_idx == 2'd3)
                        complete = seek_pair(0);
                    else
                        header_idx = header_idx + 2'd1;
                end
                CHANNEL_HEADER: begin
                    if (header_idx == 2'd0) begin
                        if ((w & FORMAT_FLAG) == '0) begin
                            r.kind       = KIND_ERROR;
                            r.channel    = 3'(2 * pair_idx);
                            r.error_code = ERR_FORMAT;
                            queue_expected(r);
                            phase = WAIT_START;
                            return;
                        end
                        block_left = (w[14:0] >= 15'd2) ? w[14:0] - 15'd2 : '0;
                        header_idx = 2'd1;
                    end else begin
                        if ((w & WAVEFORM_FLAG) == '0 || (w & TIME_TAG_FLAG) == '0) begin
                            r.kind       = KIND_ERROR;
                            r.channel    = 3'(2 * pair_idx);
                            r.error_code = ERR_DISABLED;
                            queue_expected(r);
                            phase = WAIT_START;
                            return;
                        end
                        wave_words = {w[11:0], 2'b00};
                        has_charge = w[30];
                        has_extras = w[28];
                        complete   = next_event_or_pair();
                    end
                end
                EVENT_BODY: begin
                    if (event_idx == '0) begin
                        block_left    = block_left - 15'(event_words());
                        event_odd     = w[31];
                        ch            = 3'(2 * pair_idx + event_odd);
                        channels_seen = channels_seen | (8'd1 << ch);
                        r.kind        = KIND_TIME_TAG;
                        r.channel     = ch;
                        r.time_tag    = w[30:0];
                        got           = 1'b1;
                    end else if (event_idx <= wave_words) begin
                        r.kind        = KIND_SAMPLE_PAIR;
                        r.channel     = 3'(2 * pair_idx + event_odd);
                        r.sample_low  = w[13:0];
                        r.sample_high = w[29:16];
                        r.last_pair   = (event_idx == wave_words);
                        got           = 1'b1;
                    end
                    // extras and charge words fall through with no result
                    event_idx = event_idx + 14'd1;
                    if (int'(event_idx) >= event_words())
                        complete = next_event_or_pair();
                end
                default: begin
                end
            endcase

            if (got)
                queue_expected(r);
            if (complete) begin
                if (got)
                    phase = DONE_PENDING;
                else
                    push_board_done();
            end
        endfunction

        task report(string msg);
            $display("MISMATCH: %s", msg);
            mismatch_count++;
        endtask

        task compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want)
                report($sformatf("%s expected %h got %h", name, want, got));
        endtask

        // compare one accepted result with the oldest expectation
        task check_result(logic [OUT_TDATA_W-1:0] tdata, logic [1:0] tuser, logic tlast);
            parsed_result_t want;
            if (pending_results.size() == 0) begin
                report($sformatf("unexpected result kind %0d tdata %h", tuser, tdata));
                return;
            end
            want = pending_results.pop_front();
            compare_field("kind", want.kind, tuser);
            compare_field("channel", want.channel, tdata[2:0]);
            compare_field("time_tag", want.time_tag, tdata[33:3]);
            compare_field("sample_low", want.sample_low, tdata[47:34]);
            compare_field("sample_high", want.sample_high, tdata[61:48]);
            compare_field("present_mask", want.present_mask, tdata[69:62]);
            compare_field("error_code", want.error_code, tdata[71:70]);
            compare_field("last_pair", want.last_pair, tlast);
        endtask
    endclass

endpackage

>>> sim/digitizer_event_word_parser_unit_tb.sv
// testbench top for the digitizer event word parser: directed and random readout boards
module digitizer_event_word_parser_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import dewp_pkg::*;
    import event_word_scoreboard_pkg::*;

    localparam int MAX_GAP        = 14;
    localparam int RANDOM_WORDS   = 1700;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int DRAIN_CYCLES   = 20;

    logic                   aclk     = 1'b0;
    logic                   aresetn  = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [31:0]            s_tdata  = '0;
    logic [0:0]             s_tuser  = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic [1:0]             m_tuser;
    logic                   m_tlast;

    event_word_scoreboard sb;
    bit                   idle_free   = 1'b0;
    int                   idle_cycles = 0;
    int                   words_sent  = 0;

    digitizer_event_word_parser_unit DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always #10 aclk = ~aclk;

    function int draw_gap();
        return idle_free ? 0 : $urandom_range(0, MAX_GAP);
    endfunction

    // one request on the s_ channel after a random gap
    task automatic send_word(input logic [31:0] w, input logic sof);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= w;
        s_tuser  <= sof;
        do @(posedge aclk); while (!s_tready);
    endtask

    // well-formed board with random content, now and then faulty or cut short
    task automatic random_board();
        logic [31:0] words[$];
        logic [31:0] hdr0;
        logic [31:0] hdr1;
        logic [31:0] w;
        logic [3:0]  mask;
        bit          broken;
        int          fault;
        int          evs;
        int          nev;
        int          size;
        int          keep;
        idle_free = ($urandom_range(0, 5) == 0);
        words.insert(words.size(), $urandom);
        w    = $urandom;
        mask = w[3:0];
        words.insert(words.size(), w);
        words.insert(words.size(), $urandom);
        words.insert(words.size(), $urandom);
        broken = 1'b0;
        for (int p = 0; p < PAIR_LIMIT && !broken; p++) begin
            if (mask[p]) begin
                hdr0  = $urandom | FORMAT_FLAG;
                hdr1  = $urandom | WAVEFORM_FLAG | TIME_TAG_FLAG;
                fault = $urandom_range(0, 29);
                if (fault == 0)
                    hdr0 = hdr0 & ~FORMAT_FLAG;
                else if (fault == 1)
                    hdr1 = hdr1 & ~WAVEFORM_FLAG;
                else if (fault == 2)
                    hdr1 = hdr1 & ~TIME_TAG_FLAG;
                if ($urandom_range(0, 9) == 0) begin
                    // long waveform in a block too short to hold it
                    hdr1[11:0] = 12'($urandom_range(16, 4095));
                    nev        = 0;
                    size       = $urandom_range(0, 40);
                end else begin
                    hdr1[11:0] = 12'($urandom_range(0, 3));
                    evs  = 1 + 4 * int'(hdr1[11:0]) + int'(hdr1[30]) + int'(hdr1[28]);
                    nev  = $urandom_range(0, 3);
                    size = 2 + nev * evs + $urandom_range(0, evs - 1);
                    if (nev == 0 && $urandom_range(0, 3) == 0)
                        size = $urandom_range(0, 1);
                end
                hdr0[14:0] = 15'(size);
                words.insert(words.size(), hdr0);
                words.insert(words.size(), hdr1);
                if (fault <= 2) begin
                    broken = 1'b1;
                    repeat ($urandom_range(0, 2)) words.insert(words.size(), $urandom);
                end else begin
                    for (int e = 0; e < nev; e++) begin
                        words.insert(words.size(), $urandom);
                        repeat (4 * int'(hdr1[11:0]) + int'(hdr1[30]) + int'(hdr1[28]))
                            words.insert(words.size(), $urandom);
                    end
                end
            end
        end
        // board cut short by the next start
        if ($urandom_range(0, 7) == 0) begin
            keep = $urandom_range(1, words.size());
            while (words.size() > keep) void'(words.pop_back());
        end
        foreach (words[i]) send_word(words[i], i == 0);
        words_sent += words.size();
    endtask

    // request and result monitor
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready)
                sb.check_result(m_tdata, m_tuser, m_tlast);
            if (s_tvalid && s_tready)
                sb.note_request(s_tdata, s_tuser[0]);
        end
        if (aresetn && ((m_tvalid && m_tready) || (s_tvalid && s_tready)))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    // result sink with random stalls
    initial begin : result_sink
        int stall;
        while (!aresetn) @(posedge aclk);
        forever begin
            stall = draw_gap();
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    // watchdog on cycles with no request or result
    initial begin : watchdog
        while (idle_cycles < WATCHDOG_LIMIT) @(posedge aclk);
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin : stimulus
        sb = new();
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // words ahead of any start are ignored
        send_word(32'hFFFF_FFFF, 1'b0);
        // no pair enabled: board done on the last board header word
        send_word(32'h0000_0000, 1'b1);
        send_word(32'hFFFF_FFF0, 1'b0);
        send_word(32'hFFFF_FFFF, 1'b0);
        send_word(32'h0000_0000, 1'b0);
        // pairs 0 and 3
        send_word(32'hFFFF_FFFF, 1'b1);
        send_word(32'h0000_0009, 1'b0);
        send_word(32'h0000_0000, 1'b0);
        send_word(32'h0000_0000, 1'b0);
        // pair 0: every flag, one event of four waveform words
        send_word(FORMAT_FLAG | 32'd9, 1'b0);
        send_word(CHARGE_FLAG | TIME_TAG_FLAG | EXTRAS_FLAG | WAVEFORM_FLAG | 32'd1, 1'b0);
        send_word(32'hFFFF_FFFF, 1'b0);
        send_word(32'h3FFF_3FFF, 1'b0);
        send_word(32'h0000_0000, 1'b0);
        send_word(32'hC000_C000, 1'b0);
        send_word(32'hFFFF_FFFF, 1'b0);
        send_word(32'h1234_5678, 1'b0);
        send_word(32'h0000_0000, 1'b0);
        // pair 3: two tag-only events, board ends on a result
        send_word(FORMAT_FLAG | 32'd4, 1'b0);
        send_word(TIME_TAG_FLAG | WAVEFORM_FLAG, 1'b0);
        send_word(32'h0000_0000, 1'b0);
        send_word(32'h7FFF_FFFF, 1'b0);
        // start releases the held done; format flag missing on pair 0
        send_word(32'h0000_0000, 1'b1);
        send_word(32'h0000_0001, 1'b0);
        send_word(32'h0000_0000, 1'b0);
        send_word(32'h0000_0000, 1'b0);
        send_word(32'h7FFF_7FFF, 1'b0);
        send_word(32'hFFFF_FFFF, 1'b0);

        // random boards with occasional noise in between
        while (words_sent < RANDOM_WORDS) begin
            random_board();
            if ($urandom_range(0, 9) == 0)
                repeat ($urandom_range(1, 3))
                    send_word($urandom, $urandom_range(0, 15) == 0);
        end
        // trailing word lets a held board done out
        send_word($urandom, 1'b0);
        s_tvalid <= 1'b0;

        while (sb.pending_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (sb.mismatch_count == 0 && sb.pending_results.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
